### design/time_of_use_rate_lookup_defines.svh
// assertion macros for the time-of-use rate lookup
// used by the port checker, no other dependencies
`ifndef TIME_OF_USE_RATE_LOOKUP_DEFINES_SVH
`define TIME_OF_USE_RATE_LOOKUP_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define TOU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tou check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define TOU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tou check failed");

`endif

### design/tou_pkg.sv
// types, codes and helpers for the time-of-use rate lookup
// no dependencies
`timescale 1ns / 1ps

package tou_pkg;

	localparam int MAX_RULES = 8;
	localparam int MAX_SLOTS = 16;
	localparam int DAYS_PER_MONTH = 30;
	localparam int MIN_PER_HOUR = 60;

	localparam int RULE_W = $clog2(MAX_RULES);
	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int ADDR_W = RULE_W + SLOT_W;
	localparam int RCNT_W = $clog2(MAX_RULES + 1);
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int SLOT_DEPTH = MAX_RULES * MAX_SLOTS;

	// commands
	localparam logic [1:0] CMD_QUERY = 2'd0;
	localparam logic [1:0] CMD_SEASON = 2'd1;
	localparam logic [1:0] CMD_SLOT = 2'd2;

	// result status
	localparam logic [2:0] ST_MATCH = 3'd0;
	localparam logic [2:0] ST_DISABLED = 3'd1;
	localparam logic [2:0] ST_NO_RULES = 3'd2;
	localparam logic [2:0] ST_ZERO_SLOTS = 3'd3;
	localparam logic [2:0] ST_NO_SLOT = 3'd4;
	localparam logic [2:0] ST_WRITE_DONE = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_TOU_ENABLE = 2'd0;
	localparam logic [1:0] REG_RULE_COUNT = 2'd1;
	localparam logic [1:0] REG_FLAT_RATE = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [2:0] rule_index;
		logic [3:0] slot_index;
		logic [3:0] month;
		logic [4:0] day;
		logic [3:0] end_month;
		logic [4:0] end_day;
		logic [4:0] hour;
		logic [4:0] end_hour;
		logic [5:0] minute;
		logic [4:0] slot_count;
		logic [2:0] rate_code;
	} tou_item_t;

	typedef struct packed {
		logic [2:0] rate;
		logic [2:0] matched_rule;
		logic [2:0] status;
	} tou_result_t;

	typedef struct packed {
		logic [3:0] start_month;
		logic [4:0] start_day;
		logic [3:0] end_month;
		logic [4:0] end_day;
		logic [CNT_W-1:0] count;
	} tou_season_t;

	typedef struct packed {
		logic [4:0] start_hour;
		logic [4:0] end_hour;
		logic [2:0] code;
	} tou_slot_t;

	// (month-1)*30+day, signed, month zero goes at or below one
	function automatic logic signed [10:0] tou_day_num(input logic [3:0] m,
			input logic [4:0] d);
		logic [10:0] m30;
		m30 = 11'(m) * 11'(DAYS_PER_MONTH);
		return signed'(11'(m30 + 11'(d) - 11'(DAYS_PER_MONTH)));
	endfunction

	function automatic logic [10:0] tou_hour_min(input logic [4:0] h);
		return 11'(11'(h) * 11'(MIN_PER_HOUR));
	endfunction

endpackage

### design/time_of_use_rate_lookup.sv
// time-of-use tariff rate selector: season walk and slot walk under one sequencer
// uses tou_pkg
// writes, disabled and no-rule queries go from idle straight to the done state
// queries walk the season rules, then the slots of the chosen rule, each until a hit or the last
// one word at a time: back in idle, where words are taken, as the result is loaded
// the slot walk reads one slot table entry a cycle from the slot ram, the season walk one rule
// reset: registers back to tou_enable 0, rule count 0, flat rate 2, season rules cleared at once,
// slot entries read as zero until written through per-entry valid flags, no clearing pass
`timescale 1ns / 1ps

module time_of_use_rate_lookup (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  tou_pkg::tou_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output tou_pkg::tou_result_t result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [3:0]          cfg_data
);
	import tou_pkg::*;

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SEASON = 2'd1;
	localparam logic [1:0] S_SLOT = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;

	// configuration registers
	logic tou_enable_q;
	logic [RCNT_W-1:0] rule_cnt_q;
	logic [2:0] flat_rate_q;

	// season rules, small enough for flops, cleared at reset
	tou_season_t season_q [MAX_RULES];

	// slot ram plus one valid flag per entry
	tou_slot_t slot_mem [SLOT_DEPTH];
	logic [SLOT_DEPTH-1:0] slot_vld_q;
	tou_slot_t rd_data_q;
	logic rd_vld_q;

	// walk context
	logic signed [10:0] now_day_q;
	logic [10:0] now_min_q;
	logic [RULE_W-1:0] r_q;
	logic [RULE_W-1:0] rule_q;
	logic [SLOT_W-1:0] i_q;
	logic [CNT_W-1:0] cnt_q;
	tou_result_t res_q;

	// output register
	logic result_valid_q;
	tou_result_t result_q;

	logic accept;
	logic out_free;
	logic [ADDR_W-1:0] wr_addr;
	logic wr_en;

	// season compare for the rule under the walk pointer
	tou_season_t cur_rule;
	logic signed [10:0] s_day;
	logic signed [10:0] e_day;
	logic season_hit;
	logic season_last;
	logic [RULE_W-1:0] rule_sel;
	logic [CNT_W-1:0] cnt_sel;

	// slot compare on the word read last cycle
	tou_slot_t cur_slot;
	logic [10:0] s_min;
	logic [10:0] e_min;
	logic slot_hit;
	logic slot_last;

	// slot ram read port
	logic rd_en;
	logic [ADDR_W-1:0] rd_addr;

	assign accept = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign out_free = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result = result_q;

	assign wr_en = accept && (item.cmd == CMD_SLOT) && (int'(item.rule_index) < MAX_RULES)
		&& (int'(item.slot_index) < MAX_SLOTS);
	assign wr_addr = {item.rule_index[RULE_W-1:0], item.slot_index[SLOT_W-1:0]};

	always_comb begin
		cur_rule = season_q[r_q];
		s_day = tou_day_num(cur_rule.start_month, cur_rule.start_day);
		e_day = tou_day_num(cur_rule.end_month, cur_rule.end_day);
		if (s_day <= e_day) begin
			season_hit = (now_day_q >= s_day) && (now_day_q <= e_day);
		end else begin
			// season wraps over the year end
			season_hit = (now_day_q >= s_day) || (now_day_q <= e_day);
		end
		season_last = (RCNT_W'(r_q) + RCNT_W'(1)) == rule_cnt_q;
		// no match anywhere falls back to rule 0
		rule_sel = season_hit ? r_q : '0;
		cnt_sel = season_hit ? cur_rule.count : season_q[0].count;
	end

	always_comb begin
		// an entry never written reads as zero, which covers the whole day
		cur_slot = rd_vld_q ? rd_data_q : '0;
		s_min = tou_hour_min(cur_slot.start_hour);
		e_min = tou_hour_min(cur_slot.end_hour);
		if (s_min == e_min) begin
			slot_hit = 1'b1;
		end else if (s_min < e_min) begin
			slot_hit = (now_min_q >= s_min) && (now_min_q < e_min);
		end else begin
			// slot wraps past midnight
			slot_hit = (now_min_q >= s_min) || (now_min_q < e_min);
		end
		slot_last = (CNT_W'(i_q) + CNT_W'(1)) == cnt_q;
	end

	// read the first slot as the season walk ends, then one ahead during the slot walk
	always_comb begin
		rd_en = 1'b0;
		rd_addr = {rule_q, i_q + SLOT_W'(1)};
		case (state_q)
			S_SEASON: begin
				rd_en = season_hit || season_last;
				rd_addr = {rule_sel, {SLOT_W{1'b0}}};
			end
			S_SLOT: begin
				rd_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tou_enable_q <= 1'b0;
			rule_cnt_q <= '0;
			flat_rate_q <= 3'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOU_ENABLE: tou_enable_q <= cfg_data[0];
				REG_RULE_COUNT: begin
					// saturate at table depth
					if (int'(cfg_data) > MAX_RULES) begin
						rule_cnt_q <= RCNT_W'(MAX_RULES);
					end else begin
						rule_cnt_q <= RCNT_W'(cfg_data);
					end
				end
				REG_FLAT_RATE: flat_rate_q <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// season rules
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_RULES; k++) begin
				season_q[k] <= '0;
			end
		end else if (accept && (item.cmd == CMD_SEASON)
				&& (int'(item.rule_index) < MAX_RULES)) begin
			season_q[item.rule_index[RULE_W-1:0]].start_month <= item.month;
			season_q[item.rule_index[RULE_W-1:0]].start_day <= item.day;
			season_q[item.rule_index[RULE_W-1:0]].end_month <= item.end_month;
			season_q[item.rule_index[RULE_W-1:0]].end_day <= item.end_day;
			if (int'(item.slot_count) > MAX_SLOTS) begin
				season_q[item.rule_index[RULE_W-1:0]].count <= CNT_W'(MAX_SLOTS);
			end else begin
				season_q[item.rule_index[RULE_W-1:0]].count <= CNT_W'(item.slot_count);
			end
		end
	end

	// slot ram, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= tou_slot_t'{item.hour, item.end_hour, item.rate_code};
		end
		if (rd_en) begin
			rd_data_q <= slot_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				slot_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= slot_vld_q[rd_addr];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.cmd == CMD_QUERY && tou_enable_q && rule_cnt_q != '0) begin
							state_q <= S_SEASON;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SEASON: begin
					if (season_hit || season_last) begin
						state_q <= (cnt_sel == '0) ? S_DONE : S_SLOT;
					end
				end
				S_SLOT: begin
					if (slot_hit || slot_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// walk context and pending result, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				now_day_q <= tou_day_num(item.month, item.day);
				now_min_q <= 11'(tou_hour_min(item.hour) + 11'(item.minute));
				r_q <= '0;
				i_q <= '0;
				rule_q <= '0;
				if (item.cmd == CMD_QUERY) begin
					res_q.rate <= flat_rate_q;
					res_q.matched_rule <= '0;
					res_q.status <= !tou_enable_q ? ST_DISABLED : ST_NO_RULES;
				end else begin
					// writes and the unused command
					res_q <= tou_result_t'{3'd0, 3'd0, ST_WRITE_DONE};
				end
			end
			S_SEASON: begin
				if (season_hit || season_last) begin
					rule_q <= rule_sel;
					cnt_q <= cnt_sel;
					res_q.matched_rule <= 3'(rule_sel);
					res_q.status <= (cnt_sel == '0) ? ST_ZERO_SLOTS : ST_NO_SLOT;
				end else begin
					r_q <= r_q + RULE_W'(1);
				end
			end
			S_SLOT: begin
				if (slot_hit) begin
					res_q.rate <= cur_slot.code;
					res_q.status <= ST_MATCH;
				end
				i_q <= i_q + SLOT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// output register parts the result side from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			result_q <= res_q;
		end
	end

endmodule

### design/tou_checker.sv
// port checker for the time-of-use rate lookup, bound to the top level
// uses tou_pkg and time_of_use_rate_lookup_defines.svh
`timescale 1ns / 1ps
`include "time_of_use_rate_lookup_defines.svh"

module tou_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_stall,
	input logic                 result_valid,
	input logic                 result_stall,
	input tou_pkg::tou_result_t result
);
	import tou_pkg::*;

	logic item_taken;
	logic res_held;

	assign item_taken = item_valid && !item_stall;
	assign res_held = result_valid && result_stall;

	// a stalled result word holds
	`TOU_ASSERT_NEXT(a_res_hold, res_held, result_valid && $stable(result))
	// one word at a time: busy right after taking one
	`TOU_ASSERT_NEXT(a_busy_after_take, item_taken, item_stall)
	// write results carry no rate and no rule
	`TOU_ASSERT_NOW(a_write_clean, result_valid && result.status == ST_WRITE_DONE,
		result.rate == 3'd0 && result.matched_rule == 3'd0)
	// early fallbacks never name a rule
	`TOU_ASSERT_NOW(a_fallback_rule, result_valid
		&& (result.status == ST_DISABLED || result.status == ST_NO_RULES),
		result.matched_rule == 3'd0)
	// status stays within its defined codes
	`TOU_ASSERT_NOW(a_status_range, result_valid, result.status <= ST_WRITE_DONE)

endmodule

bind time_of_use_rate_lookup tou_checker u_tou_checker (.*);

### verif/tb_time_of_use_rate_lookup.sv
// self-checking testbench for the time-of-use rate lookup: directed table cases, random phases
// and back-pressure; depends on tou_pkg and the time_of_use_rate_lookup rtl
`timescale 1ns / 1ps

module tb_time_of_use_rate_lookup;
	import tou_pkg::*;

	// codes the package leaves unnamed
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// quiet cycles before the watchdog gives up, well above the longest receiver hold-off
	localparam int QUIET_LIMIT = 4000;
	// worst-case query latency plus margin
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_MIXED_WORDS = 170;
	localparam int PROGRAM_SLOTS = 6;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	tou_item_t   item;
	logic        result_valid;
	logic        result_stall;
	tou_result_t result;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;

	time_of_use_rate_lookup dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// tariff tables and registers as the block should hold them
	tou_season_t season_rules [MAX_RULES];
	tou_slot_t   day_slots [SLOT_DEPTH];
	logic        tou_on;
	int          rules_in_use;
	logic [2:0]  flat_code;

	// expected result words, oldest first
	tou_result_t pending_tariffs [$];

	int failures;
	// 0: no idling on either side, 1: random gaps and stalls
	int idle_mode;
	// set by a test to make the receiver hold off for this many cycles
	int hold_cycles;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// (month-1)*30+day, signed so that month zero lands at or below one
	function automatic int day_of_year(input logic [3:0] m, input logic [4:0] d);
		return (int'(m) - 1) * DAYS_PER_MONTH + int'(d);
	endfunction

	// updates the tables for one word and returns the result word it should give
	function automatic tou_result_t tariff_outcome(input tou_item_t w);
		tou_result_t res;
		tou_slot_t   sl;
		int          today, s_day, e_day, rule, n, now_min, s_min, e_min;
		bit          found, hit;
		res.rate = 3'd0;
		res.matched_rule = 3'd0;
		res.status = ST_WRITE_DONE;
		case (w.cmd)
			CMD_SEASON: begin
				season_rules[w.rule_index].start_month = w.month;
				season_rules[w.rule_index].start_day = w.day;
				season_rules[w.rule_index].end_month = w.end_month;
				season_rules[w.rule_index].end_day = w.end_day;
				season_rules[w.rule_index].count = (int'(w.slot_count) > MAX_SLOTS) ?
					CNT_W'(MAX_SLOTS) : CNT_W'(w.slot_count);
			end
			CMD_SLOT: begin
				sl.start_hour = w.hour;
				sl.end_hour = w.end_hour;
				sl.code = w.rate_code;
				day_slots[int'(w.rule_index) * MAX_SLOTS + int'(w.slot_index)] = sl;
			end
			CMD_QUERY: begin
				res.rate = flat_code;
				if (!tou_on) begin
					res.status = ST_DISABLED;
				end else if (rules_in_use == 0) begin
					res.status = ST_NO_RULES;
				end else begin
					// first season that holds the date, rule 0 when none does
					today = day_of_year(w.month, w.day);
					rule = 0;
					found = 1'b0;
					for (int r = 0; r < rules_in_use; r++) begin
						s_day = day_of_year(season_rules[r].start_month, season_rules[r].start_day);
						e_day = day_of_year(season_rules[r].end_month, season_rules[r].end_day);
						if (s_day <= e_day)
							hit = (today >= s_day) && (today <= e_day);
						else
							hit = (today >= s_day) || (today <= e_day);
						if (!found && hit) begin
							rule = r;
							found = 1'b1;
						end
					end
					res.matched_rule = 3'(rule);
					n = int'(season_rules[rule].count);
					if (n > MAX_SLOTS)
						n = MAX_SLOTS;
					if (n == 0) begin
						res.status = ST_ZERO_SLOTS;
					end else begin
						// first slot that covers the minute of the day
						now_min = int'(w.hour) * MIN_PER_HOUR + int'(w.minute);
						res.status = ST_NO_SLOT;
						found = 1'b0;
						for (int i = 0; i < n; i++) begin
							sl = day_slots[rule * MAX_SLOTS + i];
							s_min = int'(sl.start_hour) * MIN_PER_HOUR;
							e_min = int'(sl.end_hour) * MIN_PER_HOUR;
							if (s_min == e_min)
								hit = 1'b1;
							else if (s_min < e_min)
								hit = (now_min >= s_min) && (now_min < e_min);
							else
								hit = (now_min >= s_min) || (now_min < e_min);
							if (!found && hit) begin
								res.rate = sl.code;
								res.status = ST_MATCH;
								found = 1'b1;
							end
						end
					end
				end
			end
			default: begin
				// unused command: stores nothing, reports a write
			end
		endcase
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (idle_mode == 0)
			return 0;
		r = int'($urandom_range(99, 0));
		if (r < 55)
			return 0;
		if (r < 93)
			return int'($urandom_range(3, 1));
		return int'($urandom_range(40, 8));
	endfunction

	// word builders: random filler in the unused fields of the random words, zeros in the fixed ones
	function automatic tou_item_t noise_word();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[$bits(tou_item_t)-1:0];
	endfunction

	function automatic tou_item_t query_at(input int m, input int d, input int h, input int mi);
		tou_item_t w;
		w = '0;
		w.cmd = CMD_QUERY;
		w.month = 4'(m);
		w.day = 5'(d);
		w.hour = 5'(h);
		w.minute = 6'(mi);
		return w;
	endfunction

	function automatic tou_item_t season_rule(input int r, input int sm, input int sd,
			input int em, input int ed, input int cnt);
		tou_item_t w;
		w = '0;
		w.cmd = CMD_SEASON;
		w.rule_index = 3'(r);
		w.month = 4'(sm);
		w.day = 5'(sd);
		w.end_month = 4'(em);
		w.end_day = 5'(ed);
		w.slot_count = 5'(cnt);
		return w;
	endfunction

	function automatic tou_item_t day_slot(input int r, input int s, input int sh, input int eh,
			input int code);
		tou_item_t w;
		w = '0;
		w.cmd = CMD_SLOT;
		w.rule_index = 3'(r);
		w.slot_index = 4'(s);
		w.hour = 5'(sh);
		w.end_hour = 5'(eh);
		w.rate_code = 3'(code);
		return w;
	endfunction

	// mostly calendar-valid queries, some with every field at full range
	function automatic tou_item_t random_query();
		tou_item_t w;
		w = noise_word();
		w.cmd = CMD_QUERY;
		if ($urandom_range(9, 0) != 0) begin
			w.month = 4'($urandom_range(12, 1));
			w.day = 5'($urandom_range(31, 1));
			w.hour = 5'($urandom_range(23, 0));
			w.minute = 6'($urandom_range(59, 0));
		end
		return w;
	endfunction

	function automatic tou_item_t random_season(input int r);
		tou_item_t w;
		int pick;
		w = noise_word();
		w.cmd = CMD_SEASON;
		w.rule_index = 3'(r);
		w.month = 4'($urandom_range(12, 1));
		w.day = 5'($urandom_range(31, 1));
		w.end_month = 4'($urandom_range(12, 1));
		w.end_day = 5'($urandom_range(31, 1));
		pick = int'($urandom_range(99, 0));
		if (pick < 10)
			w.slot_count = 5'd0;
		else if (pick < 85)
			w.slot_count = 5'($urandom_range(PROGRAM_SLOTS, 1));
		else
			w.slot_count = 5'($urandom_range(31, 7));
		return w;
	endfunction

	function automatic tou_item_t random_slot(input int r, input int s);
		tou_item_t w;
		w = noise_word();
		w.cmd = CMD_SLOT;
		w.rule_index = 3'(r);
		w.slot_index = 4'(s);
		w.hour = 5'($urandom_range(24, 0));
		// a few whole-day slots, the rest plain or wrapping past midnight
		w.end_hour = ($urandom_range(9, 0) == 0) ? w.hour : 5'($urandom_range(24, 0));
		return w;
	endfunction

	function automatic tou_item_t mixed_word();
		int pick;
		pick = int'($urandom_range(99, 0));
		if (pick < 70)
			return random_query();
		if (pick < 78)
			return random_season(int'($urandom_range(MAX_RULES - 1, 0)));
		if (pick < 90)
			return random_slot(int'($urandom_range(MAX_RULES - 1, 0)),
				int'($urandom_range(MAX_SLOTS - 1, 0)));
		return noise_word();
	endfunction

	// offers one word, returns at the edge where it is taken; valid stays high for a follow-on
	task automatic send_word(input tou_item_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (item_stall);
		pending_tariffs.push_back(tariff_outcome(w));
	endtask

	// stop offering, let every expected word arrive, then give the block time to go idle
	task automatic settle();
		item_valid <= 1'b0;
		while (pending_tariffs.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_TOU_ENABLE: tou_on = val[0];
			REG_RULE_COUNT: rules_in_use = (int'(val) > MAX_RULES) ? MAX_RULES : int'(val);
			REG_FLAT_RATE:  flat_code = val[2:0];
			default: begin
				// no register there
			end
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_tariff_regs(input int en, input int cnt, input int flat);
		settle();
		write_reg(REG_TOU_ENABLE, 4'(en));
		write_reg(REG_RULE_COUNT, 4'(cnt));
		write_reg(REG_FLAT_RATE, 4'(flat));
	endtask

	// reset values: disabled with flat rate two, unused command reports a write
	task automatic test_reset_defaults();
		send_word(query_at(1, 1, 12, 0));
		send_word(noise_word() | {CMD_UNUSED, {($bits(tou_item_t) - 2){1'b0}}});
		settle();
		write_reg(REG_TOU_ENABLE, 4'd1);
		// enabled but no rules in use
		send_word(query_at(6, 15, 8, 30));
	endtask

	task automatic test_table_cases();
		set_tariff_regs(1, 1, 2);
		// cleared tables: rule 0 has no slots
		send_word(query_at(1, 1, 12, 0));
		// season wrapping over the year end, slot count saturated
		send_word(season_rule(0, 11, 1, 2, 28, 31));
		// no season holds the date, rule 0 used; cleared slots cover the whole day
		send_word(query_at(5, 5, 10, 0));
		// slot wrapping past midnight, then a plain day slot
		send_word(day_slot(0, 0, 22, 6, 5));
		send_word(day_slot(0, 1, 8, 17, 3));
		send_word(season_rule(0, 11, 1, 2, 28, 2));
		send_word(query_at(12, 15, 23, 30));
		send_word(query_at(1, 10, 5, 59));
		// end hour is exclusive, nothing covers 06:00
		send_word(query_at(2, 28, 6, 0));
		send_word(query_at(3, 1, 8, 0));
		send_word(query_at(3, 1, 16, 59));
		send_word(season_rule(1, 6, 1, 8, 31, 1));
		send_word(day_slot(1, 0, 12, 12, 7));
		set_tariff_regs(1, 2, 2);
		// hour and minute past the clock range still fall in a whole-day slot
		send_word(query_at(7, 31, 31, 63));
		// month zero and month fifteen
		send_word(query_at(0, 0, 0, 0));
		send_word(query_at(15, 31, 23, 59));
		// extreme table positions and field values
		send_word(day_slot(7, 15, 24, 31, 7));
		send_word(season_rule(7, 15, 31, 0, 0, 16));
		send_word(day_slot(7, 0, 31, 24, 6));
		// rule count written above the table depth saturates
		set_tariff_regs(1, 15, 7);
		write_reg(REG_UNUSED, 4'hf);
		send_word(query_at(5, 5, 0, 0));
		send_word(query_at(12, 31, 24, 0));
		send_word(query_at(0, 0, 31, 63));
		set_tariff_regs(1, 8, 0);
		send_word(query_at(15, 31, 0, 0));
	endtask

	// each phase: one register setting, a fresh well-formed table load, then mixed traffic
	task automatic test_random_phases();
		int en_set [8]   = '{1, 1, 1, 0, 1, 1, 1, 1};
		int cnt_set [8]  = '{8, 3, 1, 5, 15, 0, 6, 12};
		int flat_set [8] = '{7, 0, 5, 1, 3, 4, 2, 6};
		for (int p = 0; p < 8; p++) begin
			set_tariff_regs(en_set[p], cnt_set[p], flat_set[p]);
			if (p == 4)
				write_reg(REG_UNUSED, 4'(p));
			// one phase in three runs with no idling at all
			idle_mode = (p % 3 == 2) ? 0 : 1;
			for (int r = 0; r < MAX_RULES; r++)
				send_word(random_season(r));
			for (int r = 0; r < MAX_RULES; r++)
				for (int s = 0; s < PROGRAM_SLOTS; s++)
					send_word(random_slot(r, s));
			repeat (PHASE_MIXED_WORDS) send_word(mixed_word());
		end
		idle_mode = 1;
	endtask

	task automatic test_backpressure();
		set_tariff_regs(1, 8, 4);
		idle_mode = 0;
		// receiver holds off while words keep coming, the block fills and stalls its input
		hold_cycles = HOLD_OFF_CYCLES;
		repeat (40) send_word(mixed_word());
		// sender pauses until every expected word is back
		settle();
		idle_mode = 1;
		repeat (20) send_word(mixed_word());
	endtask

	// receiver: random stall runs, or a long hold-off on request
	initial begin
		int n;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					result_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				result_stall <= 1'b0;
			end
		end
	end

	// compare each taken result word with the oldest expectation
	always @(posedge clk) begin
		tou_result_t due;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_tariffs.size() == 0) begin
				$error("result word with nothing expected: rate %0d rule %0d status %0d",
					result.rate, result.matched_rule, result.status);
				failures++;
			end else begin
				due = pending_tariffs.pop_front();
				if (result.rate !== due.rate) begin
					$error("rate: expected %0d, got %0d", due.rate, result.rate);
					failures++;
				end
				if (result.matched_rule !== due.matched_rule) begin
					$error("matched_rule: expected %0d, got %0d", due.matched_rule,
						result.matched_rule);
					failures++;
				end
				if (result.status !== due.status) begin
					$error("status: expected %0d, got %0d", due.status, result.status);
					failures++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		failures = 0;
		idle_mode = 1;
		hold_cycles = 0;
		quiet_cycles = 0;
		// model state at reset
		for (int r = 0; r < MAX_RULES; r++)
			season_rules[r] = '0;
		for (int i = 0; i < SLOT_DEPTH; i++)
			day_slots[i] = '0;
		tou_on = 1'b0;
		rules_in_use = 0;
		flat_code = 3'd2;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_table_cases();
		test_random_phases();
		test_backpressure();
		settle();

		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
